// ===== rtl/core/edp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package edp_pkg;

  localparam logic [1:0] REQ_LOAD_FIRST  = 2'd0;
  localparam logic [1:0] REQ_LOAD_SECOND = 2'd1;
  localparam logic [1:0] REQ_COMPUTE     = 2'd2;

  localparam int unsigned DIST_MAX = 127;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ROW,
    S_CELL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/edit_distance_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

// One request at a time. Load request: ready again the next cycle, no result.
// Compute request (lengths n, m after clamping): row init writes cost 0..m,
// then each row runs a row-start state and a sweep of cells 1..m, then the
// done state loads the output register once it is free. One cell per cycle
// through the shared min/compare unit and the cost row's single write port.
// Reset (rst_n, synchronous) clears the sequencer and output valid only.
module edit_distance_dp_core #(
  parameter int MAX_LEN = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_req_type,
  input  wire logic [5:0] in_index,
  input  wire logic [7:0] in_symbol,
  input  wire logic [6:0] in_first_len,
  input  wire logic [6:0] in_second_len,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [6:0]      out_distance
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int DW = (CW > 7) ? CW : 7;

  logic [7:0]    first_mem  [MAX_LEN];
  logic [7:0]    second_mem [MAX_LEN];
  logic [CW-1:0] cost_mem   [MAX_LEN+1];

  edp_pkg::state_t state_r, state_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] diag_r, diag_nxt;
  logic [CW-1:0] left_r, left_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [6:0]    out_dist_r, out_dist_nxt;

  logic [7:0]    fs_rd_r;
  logic [7:0]    ss_rd_r;
  logic [CW-1:0] cr_rd_r;

  logic          fs_we, ss_we, fs_re, cr_we;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] fs_raddr;
  logic [AW-1:0] ss_raddr;
  logic [CW-1:0] rd_col;
  logic [CW-1:0] cr_waddr;
  logic [CW-1:0] cr_wdata;
  logic          idx_ok;
  logic [CW-1:0] n_clamp, m_clamp;
  logic [CW-1:0] min_a, min_b, cell_val;
  logic [6:0]    dist_sat;

  // shared min/compare unit
  always_comb begin
    min_a    = (diag_r < cr_rd_r) ? diag_r : cr_rd_r;
    min_b    = (min_a < left_r) ? min_a : left_r;
    cell_val = (fs_rd_r == ss_rd_r) ? diag_r : min_b + 1'b1;
  end

  always_comb begin
    idx_ok   = 32'(in_index) < MAX_LEN;
    wr_addr  = AW'(in_index);
    n_clamp  = (DW'(in_first_len) > DW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(in_first_len);
    m_clamp  = (DW'(in_second_len) > DW'(MAX_LEN)) ? CW'(MAX_LEN) : CW'(in_second_len);
    dist_sat = (DW'(left_r) > DW'(edp_pkg::DIST_MAX)) ? 7'(edp_pkg::DIST_MAX)
                                                        : 7'(left_r);
  end

  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    m_nxt         = m_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    diag_nxt      = diag_r;
    left_nxt      = left_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_dist_nxt  = out_dist_r;
    in_ready      = 1'b0;
    fs_we         = 1'b0;
    ss_we         = 1'b0;
    fs_re         = 1'b0;
    cr_we         = 1'b0;
    cr_waddr      = j_r;
    cr_wdata      = j_r;
    fs_raddr      = AW'(i_r - 1'b1);
    rd_col        = CW'(1);
    case (state_r)
      edp_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (in_req_type)
            edp_pkg::REQ_LOAD_FIRST:  fs_we = idx_ok;
            edp_pkg::REQ_LOAD_SECOND: ss_we = idx_ok;
            edp_pkg::REQ_COMPUTE: begin
              n_nxt     = n_clamp;
              m_nxt     = m_clamp;
              j_nxt     = '0;
              state_nxt = edp_pkg::S_INIT;
            end
            default: ;
          endcase
        end
      end
      edp_pkg::S_INIT: begin
        cr_we    = 1'b1;
        cr_waddr = j_r;
        cr_wdata = j_r;
        if (j_r == m_r) begin
          left_nxt  = m_r;
          i_nxt     = CW'(1);
          state_nxt = (n_r == '0) ? edp_pkg::S_DONE : edp_pkg::S_ROW;
        end else begin
          j_nxt = j_r + 1'b1;
        end
      end
      edp_pkg::S_ROW: begin
        cr_we    = 1'b1;
        cr_waddr = '0;
        cr_wdata = i_r;
        fs_re    = 1'b1;
        diag_nxt = i_r - 1'b1;
        left_nxt = i_r;
        j_nxt    = CW'(1);
        rd_col   = CW'(1);
        if (m_r == '0) begin
          if (i_r == n_r) begin
            state_nxt = edp_pkg::S_DONE;
          end else begin
            i_nxt = i_r + 1'b1;
          end
        end else begin
          state_nxt = edp_pkg::S_CELL;
        end
      end
      edp_pkg::S_CELL: begin
        cr_we    = 1'b1;
        cr_waddr = j_r;
        cr_wdata = cell_val;
        left_nxt = cell_val;
        diag_nxt = cr_rd_r;
        if (j_r == m_r) begin
          rd_col = j_r;
          if (i_r == n_r) begin
            state_nxt = edp_pkg::S_DONE;
          end else begin
            i_nxt     = i_r + 1'b1;
            state_nxt = edp_pkg::S_ROW;
          end
        end else begin
          rd_col = j_r + 1'b1;
          j_nxt  = j_r + 1'b1;
        end
      end
      edp_pkg::S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = dist_sat;
          state_nxt     = edp_pkg::S_IDLE;
        end
      end
      default: state_nxt = edp_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ss_raddr = AW'(rd_col - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (fs_we) begin
      first_mem[wr_addr] <= in_symbol;
    end
    if (fs_re) begin
      fs_rd_r <= first_mem[fs_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (ss_we) begin
      second_mem[wr_addr] <= in_symbol;
    end
    ss_rd_r <= second_mem[ss_raddr];
  end

  always_ff @(posedge clk) begin
    if (cr_we) begin
      cost_mem[cr_waddr] <= cr_wdata;
    end
    cr_rd_r <= cost_mem[rd_col];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= edp_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    m_r        <= m_nxt;
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    diag_r     <= diag_nxt;
    left_r     <= left_nxt;
    out_dist_r <= out_dist_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_distance = out_dist_r;

  a_cell_col: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edp_pkg::S_CELL |-> j_r != '0 && j_r <= m_r)
    else $error("cell column out of range");

  a_row_idx: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == edp_pkg::S_ROW || state_r == edp_pkg::S_CELL)
      |-> i_r != '0 && i_r <= n_r)
    else $error("row index out of range");

  a_cell_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edp_pkg::S_CELL |-> DW'(cell_val) <= DW'(MAX_LEN))
    else $error("cell cost exceeds length bound");

  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == edp_pkg::S_DONE && (!out_valid_r || out_ready) |=> out_valid_r)
    else $error("finished compute gave no result");

endmodule

`default_nettype wire
